// ===== src/lba_pkg.sv =====
// ----------------------------------------------------------------------------
// lba_pkg
// Shared codes and field widths of the linked block allocator.
// ----------------------------------------------------------------------------
package lba_pkg;

    localparam int KEY_W    = 32;
    localparam int CNT_W    = 7;
    localparam int STATUS_W = 3;
    localparam int START_W  = 6;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_CREATED   = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_DIR_FULL  = 3'd3,
        ST_ZERO_REQ  = 3'd4,
        ST_DELETED   = 3'd5,
        ST_NOT_FOUND = 3'd6
    } status_t;

    localparam logic CMD_CREATE = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // register index is the word address above the byte offset
    localparam logic [ADDR_W-3:0] REG_BLOCKS_IN_USE = 1'b0;

endpackage

// ===== src/lba_if.sv =====
// ----------------------------------------------------------------------------
// lba_if
// Request and response channels of the linked block allocator.
// ----------------------------------------------------------------------------
interface lba_req_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [lba_pkg::KEY_W-1:0]  file_key;
    logic [lba_pkg::CNT_W-1:0]  block_count;

    modport source (output valid, cmd, file_key, block_count, input ready);
    modport sink   (input valid, cmd, file_key, block_count, output ready);
endinterface

interface lba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lba_pkg::STATUS_W-1:0]  status;
    logic [lba_pkg::START_W-1:0]   start_block;
    logic [lba_pkg::CNT_W-1:0]     blocks_freed;

    modport source (output valid, status, start_block, blocks_freed, input ready);
    modport sink   (input valid, status, start_block, blocks_freed, output ready);
endinterface

// ===== src/lba_block_store.sv =====
// ----------------------------------------------------------------------------
// lba_block_store
// Per-block used flag and link, one write and one read port, registered read
// with write-to-read forwarding when both ports hit the same block.
// ----------------------------------------------------------------------------
module lba_block_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_q_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q_reg;

endmodule

// ===== src/linked_block_allocator.sv =====
// ----------------------------------------------------------------------------
// linked_block_allocator
// Linked allocation of disk blocks with a small file directory.
// ----------------------------------------------------------------------------
// Requests arrive on req (cmd, file_key, block_count); each gives exactly one
// item on rsp (status, start_block, blocks_freed). req is ready only while the
// controller is idle, so one request is worked on at a time; a finished item
// sits in the output register and the next request is taken while it waits.
// The directory is scanned first; then a create reads blocks in first-fit
// order up to the last block it takes, and a delete walks the chain block by
// block. Rejected requests finish right after the scan. The block store has
// one read and one write port; the chain walk reads the next block while it
// frees the current one. After reset, and after any write of blocks_in_use
// through the APB port, all NUM_BLOCKS blocks of the store are swept (req
// held not ready) and the directory is emptied. If rsp is stalled, the
// finished item holds and a second finished item waits inside until the
// first is taken.
// ----------------------------------------------------------------------------
module linked_block_allocator #(
    parameter int NUM_BLOCKS  = 64,
    parameter int DIR_ENTRIES = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lba_req_if.sink                      req,
    lba_rsp_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lba_pkg::ADDR_W-1:0]   paddr,
    input  logic [lba_pkg::DATA_W-1:0]   pwdata,
    output logic [lba_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int CW = (LW > lba_pkg::CNT_W) ? LW : lba_pkg::CNT_W;
    localparam int DW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int SW = $clog2(DIR_ENTRIES + 1);
    localparam logic [LW-1:0] END_MARK = LW'(NUM_BLOCKS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_ALLOC,
        S_FIN,
        S_WALK_START,
        S_WALK,
        S_DEL_FIN,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [BW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [LW-1:0]              blocks_reg, blocks_next;
    logic [LW-1:0]              free_reg, free_next;
    logic [DIR_ENTRIES-1:0]     dir_valid_reg, dir_valid_next;

    logic                       cmd_reg, cmd_next;
    logic [lba_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [lba_pkg::CNT_W-1:0]  want_reg, want_next;

    logic [SW-1:0]              scan_idx_reg, scan_idx_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic [DW-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                       found_reg, found_next;
    logic [DW-1:0]              found_slot_reg, found_slot_next;
    logic                       free_ok_reg, free_ok_next;
    logic [DW-1:0]              free_slot_reg, free_slot_next;

    logic [LW-1:0]              blk_idx_reg, blk_idx_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic [BW-1:0]              eval_idx_reg, eval_idx_next;
    logic [BW-1:0]              prev_reg, prev_next;
    logic [BW-1:0]              start_reg, start_next;
    logic [lba_pkg::CNT_W-1:0]  left_reg, left_next;
    logic                       first_reg, first_next;

    logic [LW-1:0]              cur_reg, cur_next;
    logic [LW-1:0]              freed_reg, freed_next;
    logic [LW-1:0]              steps_reg, steps_next;

    logic [lba_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [lba_pkg::START_W-1:0]  res_start_reg, res_start_next;
    logic [lba_pkg::CNT_W-1:0]    res_freed_reg, res_freed_next;

    logic                         out_valid_reg, out_valid_next;
    logic [lba_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [lba_pkg::START_W-1:0]  out_start_reg, out_start_next;
    logic [lba_pkg::CNT_W-1:0]    out_freed_reg, out_freed_next;

    // block store ports
    logic          st_wr_en;
    logic [BW-1:0] st_wr_addr;
    logic [LW:0]   st_wr_data;
    logic          st_rd_en;
    logic [BW-1:0] st_rd_addr;
    logic [LW:0]   st_rd_data;
    logic          st_rd_used;
    logic [LW-1:0] st_rd_link;

    // directory key and start store
    logic [lba_pkg::KEY_W-1:0] dir_key_mem [DIR_ENTRIES];
    logic [BW-1:0]             dir_start_mem [DIR_ENTRIES];
    logic [lba_pkg::KEY_W-1:0] dir_key_q;
    logic [BW-1:0]             dir_start_q;
    logic                      dir_rd_en;
    logic [DW-1:0]             dir_rd_addr;
    logic                      dir_wr_en;

    logic                      cfg_hit;
    logic [lba_pkg::CNT_W-1:0] cfg_val;

    lba_block_store #(
        .DEPTH  (NUM_BLOCKS),
        .ADDR_W (BW),
        .DATA_W (LW + 1)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    assign st_rd_used = st_rd_data[LW];
    assign st_rd_link = st_rd_data[LW-1:0];

    always_ff @(posedge clk)
    begin
        if (dir_wr_en)
        begin
            dir_key_mem[free_slot_reg]   <= key_reg;
            dir_start_mem[free_slot_reg] <= start_reg;
        end
        if (dir_rd_en)
        begin
            dir_key_q   <= dir_key_mem[dir_rd_addr];
            dir_start_q <= dir_start_mem[dir_rd_addr];
        end
    end

    // configuration port
    assign pready  = 1'b1;
    assign cfg_val = pwdata[lba_pkg::CNT_W-1:0];
    assign cfg_hit = psel && penable && pwrite
                     && (paddr[lba_pkg::ADDR_W-1:2] == lba_pkg::REG_BLOCKS_IN_USE);
    assign prdata  = (paddr[lba_pkg::ADDR_W-1:2] == lba_pkg::REG_BLOCKS_IN_USE)
                     ? lba_pkg::DATA_W'(blocks_reg) : '0;

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.start_block  = out_start_reg;
    assign rsp.blocks_freed = out_freed_reg;

    always_comb
    begin
        logic          slot_vld;
        logic [LW:0]   free_sum;
        logic [LW-1:0] steps_inc;

        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        blocks_next     = blocks_reg;
        free_next       = free_reg;
        dir_valid_next  = dir_valid_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        want_next       = want_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        free_ok_next    = free_ok_reg;
        free_slot_next  = free_slot_reg;
        blk_idx_next    = blk_idx_reg;
        rd_pend_next    = rd_pend_reg;
        eval_idx_next   = eval_idx_reg;
        prev_next       = prev_reg;
        start_next      = start_reg;
        left_next       = left_reg;
        first_next      = first_reg;
        cur_next        = cur_reg;
        freed_next      = freed_reg;
        steps_next      = steps_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_freed_next  = res_freed_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_freed_next  = out_freed_reg;

        st_wr_en    = 1'b0;
        st_wr_addr  = '0;
        st_wr_data  = '0;
        st_rd_en    = 1'b0;
        st_rd_addr  = '0;
        dir_rd_en   = 1'b0;
        dir_rd_addr = '0;
        dir_wr_en   = 1'b0;

        slot_vld  = dir_valid_reg[cmp_idx_reg];
        free_sum  = {1'b0, free_reg} + {1'b0, freed_reg};
        steps_inc = LW'(steps_reg + 1'b1);

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = clr_cnt_reg;
                st_wr_data = {1'b0, END_MARK};
                if (clr_cnt_reg == BW'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = BW'(clr_cnt_reg + 1'b1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next      = req.cmd;
                    key_next      = req.file_key;
                    want_next     = req.block_count;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    found_next    = 1'b0;
                    free_ok_next  = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // compare the slot read last cycle; lowest slot wins
                if (cmp_vld_reg)
                begin
                    if (slot_vld && (dir_key_q == key_reg) && !found_reg)
                    begin
                        found_next      = 1'b1;
                        found_slot_next = cmp_idx_reg;
                    end
                    if (!slot_vld && !free_ok_reg)
                    begin
                        free_ok_next   = 1'b1;
                        free_slot_next = cmp_idx_reg;
                    end
                end
                if (scan_idx_reg == SW'(DIR_ENTRIES))
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = S_DECIDE;
                end
                else
                begin
                    dir_rd_en     = 1'b1;
                    dir_rd_addr   = scan_idx_reg[DW-1:0];
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[DW-1:0];
                    scan_idx_next = SW'(scan_idx_reg + 1'b1);
                end
            end

            S_DECIDE:
            begin
                res_start_next = '0;
                res_freed_next = '0;
                if (cmd_reg == lba_pkg::CMD_CREATE)
                begin
                    state_next = S_RESP;
                    if (found_reg)
                    begin
                        res_status_next = lba_pkg::ST_EXISTS;
                    end
                    else if (want_reg == '0)
                    begin
                        res_status_next = lba_pkg::ST_ZERO_REQ;
                    end
                    else if (!free_ok_reg)
                    begin
                        res_status_next = lba_pkg::ST_DIR_FULL;
                    end
                    else if (CW'(want_reg) > CW'(free_reg))
                    begin
                        res_status_next = lba_pkg::ST_NO_SPACE;
                    end
                    else
                    begin
                        blk_idx_next = '0;
                        rd_pend_next = 1'b0;
                        left_next    = want_reg;
                        first_next   = 1'b1;
                        start_next   = '0;
                        state_next   = S_ALLOC;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        dir_rd_en   = 1'b1;
                        dir_rd_addr = found_slot_reg;
                        state_next  = S_WALK_START;
                    end
                    else
                    begin
                        res_status_next = lba_pkg::ST_NOT_FOUND;
                        state_next      = S_RESP;
                    end
                end
            end

            S_ALLOC:
            begin
                if (rd_pend_reg && !st_rd_used && (left_reg == 7'd1))
                begin
                    // last block of the request: its own link is closed in S_FIN
                    if (!first_reg)
                    begin
                        st_wr_en   = 1'b1;
                        st_wr_addr = prev_reg;
                        st_wr_data = {1'b1, LW'(eval_idx_reg)};
                    end
                    else
                    begin
                        start_next = eval_idx_reg;
                    end
                    prev_next    = eval_idx_reg;
                    left_next    = '0;
                    rd_pend_next = 1'b0;
                    state_next   = S_FIN;
                end
                else
                begin
                    if (rd_pend_reg && !st_rd_used)
                    begin
                        if (first_reg)
                        begin
                            start_next = eval_idx_reg;
                            first_next = 1'b0;
                        end
                        else
                        begin
                            st_wr_en   = 1'b1;
                            st_wr_addr = prev_reg;
                            st_wr_data = {1'b1, LW'(eval_idx_reg)};
                        end
                        prev_next = eval_idx_reg;
                        left_next = lba_pkg::CNT_W'(left_reg - 1'b1);
                    end
                    if (CW'(blk_idx_reg) < CW'(blocks_reg))
                    begin
                        st_rd_en      = 1'b1;
                        st_rd_addr    = blk_idx_reg[BW-1:0];
                        eval_idx_next = blk_idx_reg[BW-1:0];
                        rd_pend_next  = 1'b1;
                        blk_idx_next  = LW'(blk_idx_reg + 1'b1);
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                        if (!rd_pend_reg)
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
            end

            S_FIN:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = prev_reg;
                st_wr_data = {1'b1, END_MARK};
                free_next  = LW'(free_reg - LW'(want_reg));
                dir_valid_next[free_slot_reg] = 1'b1;
                dir_wr_en       = 1'b1;
                res_status_next = lba_pkg::ST_CREATED;
                res_start_next  = lba_pkg::START_W'(start_reg);
                res_freed_next  = '0;
                state_next      = S_RESP;
            end

            S_WALK_START:
            begin
                cur_next   = LW'(dir_start_q);
                freed_next = '0;
                steps_next = '0;
                if (CW'(dir_start_q) < CW'(blocks_reg))
                begin
                    st_rd_en   = 1'b1;
                    st_rd_addr = dir_start_q;
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_DEL_FIN;
                end
            end

            S_WALK:
            begin
                // free the current block while the next one is read
                st_wr_en   = 1'b1;
                st_wr_addr = cur_reg[BW-1:0];
                st_wr_data = {1'b0, END_MARK};
                freed_next = LW'(freed_reg + LW'(st_rd_used));
                steps_next = steps_inc;
                if ((CW'(st_rd_link) < CW'(blocks_reg)) && (steps_inc < END_MARK))
                begin
                    st_rd_en   = 1'b1;
                    st_rd_addr = st_rd_link[BW-1:0];
                    cur_next   = st_rd_link;
                end
                else
                begin
                    state_next = S_DEL_FIN;
                end
            end

            S_DEL_FIN:
            begin
                if (free_sum > {1'b0, blocks_reg})
                begin
                    free_next = blocks_reg;
                end
                else
                begin
                    free_next = LW'(free_sum);
                end
                dir_valid_next[found_slot_reg] = 1'b0;
                res_status_next = lba_pkg::ST_DELETED;
                res_start_next  = '0;
                res_freed_next  = lba_pkg::CNT_W'(freed_reg);
                state_next      = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    out_freed_next  = res_freed_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write restarts the disk with the new block count
        if (cfg_hit)
        begin
            if (cfg_val == '0)
            begin
                blocks_next = LW'(1);
            end
            else if (CW'(cfg_val) > CW'(NUM_BLOCKS))
            begin
                blocks_next = END_MARK;
            end
            else
            begin
                blocks_next = LW'(cfg_val);
            end
            free_next      = blocks_next;
            dir_valid_next = '0;
            clr_cnt_next   = '0;
            state_next     = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            blocks_reg    <= END_MARK;
            free_reg      <= END_MARK;
            dir_valid_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_ok_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            blocks_reg    <= blocks_next;
            free_reg      <= free_next;
            dir_valid_reg <= dir_valid_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            free_ok_reg   <= free_ok_next;
            rd_pend_reg   <= rd_pend_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        want_reg       <= want_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_slot_reg <= found_slot_next;
        free_slot_reg  <= free_slot_next;
        blk_idx_reg    <= blk_idx_next;
        eval_idx_reg   <= eval_idx_next;
        prev_reg       <= prev_next;
        start_reg      <= start_next;
        left_reg       <= left_next;
        cur_reg        <= cur_next;
        freed_reg      <= freed_next;
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_freed_reg  <= res_freed_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_freed_reg  <= out_freed_next;
    end

endmodule

// ===== bench/tb_linked_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linked_block_allocator
// Self-checking bench for the linked block allocator. A scoreboard keeps its
// own block map, chain links and file directory and predicts every response.
// A directed part is followed by random create/delete traffic over several
// disk sizes. Both channels idle at random, and one long response stall fills
// the block.
// ----------------------------------------------------------------------------
module tb_linked_block_allocator;

    localparam int NUM_BLOCKS  = 64;
    localparam int DIR_ENTRIES = 10;
    localparam int KEY_POOL    = 14;
    localparam int LONG_HOLD   = 400;
    localparam int QUIET_LIMIT = 4000;

    localparam logic [lba_pkg::ADDR_W-3:0] REG_UNMAPPED = 1'b1;

    typedef struct {
        lba_pkg::status_t              status;
        logic [lba_pkg::START_W-1:0]   start_block;
        logic [lba_pkg::CNT_W-1:0]     blocks_freed;
    } alloc_result_t;

    class block_map_scoreboard;
        int unsigned                 managed;
        bit                          used [NUM_BLOCKS];
        int unsigned                 link [NUM_BLOCKS];
        bit                          entry_valid [DIR_ENTRIES];
        logic [lba_pkg::KEY_W-1:0]   entry_key [DIR_ENTRIES];
        int unsigned                 entry_start [DIR_ENTRIES];
        int unsigned                 free_blocks;
        alloc_result_t               expected_q[$];
        int unsigned                 failures;
        int unsigned                 requests;
        int unsigned                 settings;
        int unsigned                 seen [7];

        function new();
            managed = NUM_BLOCKS;
            failures = 0;
            requests = 0;
            settings = 0;
            foreach (seen[i])
            begin
                seen[i] = 0;
            end
            clear_disk();
        endfunction

        function void clear_disk();
            foreach (used[i])
            begin
                used[i] = 1'b0;
                link[i] = NUM_BLOCKS;
            end
            foreach (entry_valid[i])
            begin
                entry_valid[i] = 1'b0;
                entry_key[i] = '0;
                entry_start[i] = 0;
            end
            free_blocks = managed;
        endfunction

        // out-of-range sizes clamp; other register indexes are ignored
        function void write_register(logic [lba_pkg::ADDR_W-3:0] index,
                                     logic [lba_pkg::DATA_W-1:0] value);
            int unsigned v;
            if (index != lba_pkg::REG_BLOCKS_IN_USE)
                return;
            v = value & 32'h7F;
            if (v < 1)
                v = 1;
            if (v > NUM_BLOCKS)
                v = NUM_BLOCKS;
            managed = v;
            settings++;
            clear_disk();
        endfunction

        function int find_key(logic [lba_pkg::KEY_W-1:0] key);
            for (int i = 0; i < DIR_ENTRIES; i++)
                if (entry_valid[i] && entry_key[i] == key)
                    return i;
            return -1;
        endfunction

        function void note_request(logic cmd, logic [lba_pkg::KEY_W-1:0] key,
                                   logic [lba_pkg::CNT_W-1:0] want);
            alloc_result_t r;
            int          slot;
            int unsigned prev, left, cur, nxt, freed, steps;
            bit          first;
            r.status = lba_pkg::ST_CREATED;
            r.start_block = '0;
            r.blocks_freed = '0;
            requests++;
            slot = find_key(key);
            if (cmd == lba_pkg::CMD_CREATE)
            begin
                if (slot >= 0)
                    r.status = lba_pkg::ST_EXISTS;
                else if (want == 0)
                    r.status = lba_pkg::ST_ZERO_REQ;
                else
                begin
                    for (int i = 0; i < DIR_ENTRIES; i++)
                        if (!entry_valid[i] && slot < 0)
                            slot = i;
                    if (slot < 0)
                        r.status = lba_pkg::ST_DIR_FULL;
                    else if (want > free_blocks)
                        r.status = lba_pkg::ST_NO_SPACE;
                    else
                    begin
                        // first fit, chained in ascending block order
                        first = 1'b1;
                        prev = NUM_BLOCKS;
                        left = want;
                        for (int i = 0; i < managed && left > 0; i++)
                        begin
                            if (!used[i])
                            begin
                                used[i] = 1'b1;
                                link[i] = NUM_BLOCKS;
                                if (first)
                                begin
                                    r.start_block = i;
                                    first = 1'b0;
                                end
                                else
                                    link[prev] = i;
                                prev = i;
                                left--;
                            end
                        end
                        free_blocks -= want;
                        entry_valid[slot] = 1'b1;
                        entry_key[slot] = key;
                        entry_start[slot] = r.start_block;
                    end
                end
            end
            else if (slot < 0)
                r.status = lba_pkg::ST_NOT_FOUND;
            else
            begin
                cur = entry_start[slot];
                freed = 0;
                steps = 0;
                while (cur < managed && steps < NUM_BLOCKS)
                begin
                    nxt = link[cur];
                    if (used[cur])
                    begin
                        used[cur] = 1'b0;
                        freed++;
                    end
                    link[cur] = NUM_BLOCKS;
                    cur = nxt;
                    steps++;
                end
                free_blocks = (free_blocks + freed > managed) ? managed
                                                              : free_blocks + freed;
                entry_valid[slot] = 1'b0;
                r.status = lba_pkg::ST_DELETED;
                r.blocks_freed = freed;
            end
            expected_q.push_back(r);
        endfunction

        function void check_response(logic [lba_pkg::STATUS_W-1:0] status,
                                     logic [lba_pkg::START_W-1:0] start_block,
                                     logic [lba_pkg::CNT_W-1:0] blocks_freed);
            alloc_result_t exp;
            if (expected_q.size() == 0)
            begin
                $error("unexpected response item: status %0d start_block %0d blocks_freed %0d",
                       status, start_block, blocks_freed);
                failures++;
                return;
            end
            exp = expected_q.pop_front();
            seen[exp.status]++;
            if (status !== exp.status)
            begin
                $error("status: expected %0d, actual %0d", exp.status, status);
                failures++;
            end
            if (start_block !== exp.start_block)
            begin
                $error("start_block: expected %0d, actual %0d", exp.start_block, start_block);
                failures++;
            end
            if (blocks_freed !== exp.blocks_freed)
            begin
                $error("blocks_freed: expected %0d, actual %0d", exp.blocks_freed, blocks_freed);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [lba_pkg::ADDR_W-1:0] paddr;
    logic [lba_pkg::DATA_W-1:0] pwdata;
    logic [lba_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    lba_req_if req_ch ();
    lba_rsp_if rsp_ch ();

    block_map_scoreboard sb;
    int snd_idle_pct;
    int rcv_idle_pct;
    bit long_hold_req;

    linked_block_allocator #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .DIR_ENTRIES (DIR_ENTRIES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:
            begin
                snd_idle_pct = 30;
                rcv_idle_pct = 72;
            end
            1:
            begin
                snd_idle_pct = 72;
                rcv_idle_pct = 30;
            end
            default:
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_request(input logic cmd, input logic [lba_pkg::KEY_W-1:0] key,
                                input logic [lba_pkg::CNT_W-1:0] count);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.file_key    <= key;
        req_ch.block_count <= count;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(cmd, key, count);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic cfg_write(input logic [lba_pkg::ADDR_W-3:0] index,
                             input logic [lba_pkg::DATA_W-1:0] value);
        wait_drained();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(index, value);
    endtask

    function automatic logic [lba_pkg::CNT_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 4);
        if (r < 90)
            return $urandom_range(5, 16);
        if (r < 97)
            return $urandom_range(1, NUM_BLOCKS);
        return NUM_BLOCKS;
    endfunction

    task automatic run_random(input int n_items, input int mode, input bit with_hold,
                              input bit with_pause);
        logic [lba_pkg::KEY_W-1:0] pool [KEY_POOL];
        logic [lba_pkg::KEY_W-1:0] key;
        int                        pick;
        int                        n;
        set_idle_mode(mode);
        foreach (pool[i])
        begin
            pool[i] = $urandom;
        end
        for (n = 0; n < n_items; n++)
        begin
            if (with_hold && n == 100)
                long_hold_req = 1'b1;
            if (with_pause && n == n_items / 2)
                wait_drained();
            pick = $urandom_range(0, 99);
            key = pool[$urandom_range(0, KEY_POOL - 1)];
            // pool keys outnumber directory slots, so full, exists and not found all occur
            if (pick < 48)
                send_request(lba_pkg::CMD_CREATE, key, pick_size());
            else if (pick < 85)
                send_request(lba_pkg::CMD_DELETE, key, $urandom_range(0, NUM_BLOCKS));
            else if (pick < 92)
                send_request($urandom_range(0, 1), $urandom, $urandom_range(0, NUM_BLOCKS));
            else if (pick < 96)
                send_request(lba_pkg::CMD_CREATE, key, 0);
            else
                send_request(lba_pkg::CMD_CREATE, $urandom, $urandom_range(0, NUM_BLOCKS));
        end
    endtask

    task automatic run_directed();
        set_idle_mode(0);
        send_request(lba_pkg::CMD_DELETE, 32'h0000_0000, 0);
        send_request(lba_pkg::CMD_CREATE, 32'h0000_0000, 0);
        send_request(lba_pkg::CMD_CREATE, 32'hFFFF_FFFF, NUM_BLOCKS);
        send_request(lba_pkg::CMD_CREATE, 32'h0000_0001, 1);
        // existing key wins over a zero count
        send_request(lba_pkg::CMD_CREATE, 32'hFFFF_FFFF, 0);
        send_request(lba_pkg::CMD_DELETE, 32'hFFFF_FFFF, 0);
        send_request(lba_pkg::CMD_DELETE, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < DIR_ENTRIES; i++)
            send_request(lba_pkg::CMD_CREATE, 32'h5A5A_5A50 + i, 2);
        // zero count is rejected before the full directory
        send_request(lba_pkg::CMD_CREATE, 32'h0000_0007, 0);
        send_request(lba_pkg::CMD_CREATE, 32'h0000_0007, 1);
        send_request(lba_pkg::CMD_DELETE, 32'h5A5A_5A52, 0);
        // lands in the hole first, then continues past the used blocks
        send_request(lba_pkg::CMD_CREATE, 32'h0000_0007, 5);
        send_request(lba_pkg::CMD_DELETE, 32'h5A5A_5A50, NUM_BLOCKS);
        send_request(lba_pkg::CMD_CREATE, 32'hA5A5_A5A5, NUM_BLOCKS);
        send_request(lba_pkg::CMD_DELETE, 32'h0000_0007, 0);
    endtask

    initial
    begin : response_sink
        int hold_left;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    initial
    begin : response_monitor
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.start_block, rsp_ch.blocks_freed);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = lba_pkg::CMD_CREATE;
        req_ch.file_key    = '0;
        req_ch.block_count = '0;
        long_hold_req      = 1'b0;
        sb = new();
        set_idle_mode(2);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        cfg_write(lba_pkg::REG_BLOCKS_IN_USE, NUM_BLOCKS);
        run_random(300, 1, 1'b0, 1'b0);
        cfg_write(lba_pkg::REG_BLOCKS_IN_USE, 1);
        run_random(200, 2, 1'b0, 1'b0);
        // zero clamps up to a single block
        cfg_write(lba_pkg::REG_BLOCKS_IN_USE, 0);
        run_random(150, 0, 1'b0, 1'b0);
        cfg_write(lba_pkg::REG_BLOCKS_IN_USE, 127);
        cfg_write(REG_UNMAPPED, 3);
        run_random(300, 0, 1'b1, 1'b0);
        // only the low register bits count
        cfg_write(lba_pkg::REG_BLOCKS_IN_USE, 32'hFFFF_FF8C);
        run_random(300, 1, 1'b0, 1'b1);
        cfg_write(lba_pkg::REG_BLOCKS_IN_USE, 33);
        run_random(300, 2, 1'b0, 1'b0);
        cfg_write(lba_pkg::REG_BLOCKS_IN_USE, 2);
        run_random(250, 0, 1'b0, 1'b0);

        wait_drained();
        repeat (120) @(posedge clk);

        $display("covered %0d requests over %0d disk sizes, with back-pressure and idle gaps",
                 sb.requests, sb.settings);
        $display("created %0d, exists %0d, too few free %0d, dir full %0d,",
                 sb.seen[lba_pkg::ST_CREATED], sb.seen[lba_pkg::ST_EXISTS],
                 sb.seen[lba_pkg::ST_NO_SPACE], sb.seen[lba_pkg::ST_DIR_FULL]);
        $display("zero %0d, deleted %0d, missing %0d",
                 sb.seen[lba_pkg::ST_ZERO_REQ], sb.seen[lba_pkg::ST_DELETED],
                 sb.seen[lba_pkg::ST_NOT_FOUND]);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
